>>> src/hhbp_pkg.sv
// shared types and constants of the http/1.x header byte parser
// no dependencies
package hhbp_pkg;

	typedef enum logic [4:0] {
		PH_START        = 5'd0,
		PH_METHOD       = 5'd1,
		PH_TARGET_FIRST = 5'd2,
		PH_TARGET       = 5'd3,
		PH_QVERSION     = 5'd4,
		PH_QEOL         = 5'd5,
		PH_LINE_LF      = 5'd6,
		PH_RVERSION     = 5'd7,
		PH_RVER_SEP     = 5'd8,
		PH_CODE         = 5'd9,
		PH_CODE_SEP     = 5'd10,
		PH_REASON_FIRST = 5'd11,
		PH_REASON       = 5'd12,
		PH_FIELD_START  = 5'd13,
		PH_NAME         = 5'd14,
		PH_OWS          = 5'd15,
		PH_VALUE        = 5'd16,
		PH_FIELD_LF     = 5'd17,
		PH_FINAL_LF     = 5'd18,
		PH_DONE         = 5'd19,
		PH_FAILED       = 5'd20
	} phase_t;

	localparam logic [3:0] CLS_METHOD = 4'd0;
	localparam logic [3:0] CLS_TARGET = 4'd1;
	localparam logic [3:0] CLS_VERSION = 4'd2;
	localparam logic [3:0] CLS_CODE = 4'd3;
	localparam logic [3:0] CLS_REASON = 4'd4;
	localparam logic [3:0] CLS_NAME = 4'd5;
	localparam logic [3:0] CLS_VALUE = 4'd6;
	localparam logic [3:0] CLS_SEP = 4'd7;
	localparam logic [3:0] CLS_EOL = 4'd8;
	localparam logic [3:0] CLS_IDLE = 4'd9;

	localparam logic [3:0] ERR_NONE = 4'd0;
	localparam logic [3:0] ERR_METHOD_SEP = 4'd1;
	localparam logic [3:0] ERR_VERSION = 4'd2;
	localparam logic [3:0] ERR_VER_SEP = 4'd3;
	localparam logic [3:0] ERR_CODE_DIGIT = 4'd4;
	localparam logic [3:0] ERR_CODE_SEP = 4'd5;
	localparam logic [3:0] ERR_BAD_CHAR = 4'd6;
	localparam logic [3:0] ERR_CRLF = 4'd7;
	localparam logic [3:0] ERR_NAME_SEP = 4'd8;

	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7f;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE = 8'h31;

	// byte classes precomputed by the front part
	typedef struct packed {
		logic [7:0] data;
		logic       restart;
		logic       is_tchar;
		logic       is_digit;
		logic       is_vchar;
		logic       is_sp;
		logic       is_cr;
		logic       is_lf;
		logic       is_colon;
	} cls_beat_t;

	typedef struct packed {
		logic [3:0] byte_class;
		logic       token_first;
		logic       field_done;
		logic       header_done;
		logic       error_flag;
		logic [3:0] error_code;
		logic [9:0] status_code;
		logic       version_minor;
	} result_t;

	function automatic logic [7:0] ver_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0: c = 8'h48;
			3'd1: c = 8'h54;
			3'd2: c = 8'h54;
			3'd3: c = 8'h50;
			3'd4: c = 8'h2f;
			3'd5: c = 8'h31;
			default: c = 8'h2e;
		endcase
		return c;
	endfunction

	function automatic logic tchar(input logic [7:0] c);
		logic r;
		r = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
			|| ((c >= 8'h30) && (c <= 8'h39));
		unique case (c)
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2a, 8'h2b,
			8'h2d, 8'h2e, 8'h5e, 8'h5f, 8'h60, 8'h7c, 8'h7e: r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

endpackage

>>> src/hhbp_front.sv
// front part: takes input beats, classifies each byte, holds a two-entry queue
// depends on hhbp_pkg
module hhbp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           data_byte,
	input  logic                 start_of_message,
	input  logic                 push,
	output logic                 full,
	output hhbp_pkg::cls_beat_t  beat,
	output logic                 beat_valid,
	input  logic                 beat_take
);

	hhbp_pkg::cls_beat_t ent_q [2];
	logic                rd_q;
	logic                wr_q;
	logic [1:0]          cnt_q;
	hhbp_pkg::cls_beat_t nb;
	logic                do_push;
	logic                do_pop;

	always_comb begin
		nb.data     = data_byte;
		nb.restart  = start_of_message;
		nb.is_tchar = hhbp_pkg::tchar(data_byte);
		nb.is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
		nb.is_vchar = (data_byte >= hhbp_pkg::CH_SP) && (data_byte != hhbp_pkg::CH_DEL);
		nb.is_sp    = data_byte == hhbp_pkg::CH_SP;
		nb.is_cr    = data_byte == hhbp_pkg::CH_CR;
		nb.is_lf    = data_byte == hhbp_pkg::CH_LF;
		nb.is_colon = data_byte == hhbp_pkg::CH_COLON;
	end

	assign full       = cnt_q == 2'd2;
	assign beat_valid = cnt_q != 2'd0;
	assign beat       = ent_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = beat_take && beat_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= nb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

>>> src/hhbp_back.sv
// back part: parse state machine and two-entry result queue
// depends on hhbp_pkg
module hhbp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 message_kind,
	input  hhbp_pkg::cls_beat_t  beat,
	input  logic                 beat_valid,
	output logic                 beat_take,
	output hhbp_pkg::result_t    res,
	output logic                 empty,
	input  logic                 pop
);

	hhbp_pkg::phase_t  phase_q, ph, ph_n;
	logic [2:0]        vpos_q, vp, vp_n;
	logic [1:0]        dcnt_q, dc, dc_n;
	logic [9:0]        acc_q, ac, ac_n;
	logic              minor_q, mi, mi_n;
	logic [3:0]        err_q, er, er_n;
	logic [3:0]        cls;
	logic              first, fdone, hdone;
	logic [3:0]        e;
	logic [9:0]        mul10;

	hhbp_pkg::result_t rq_q [2];
	logic              rrd_q, rwr_q;
	logic [1:0]        rcnt_q;
	hhbp_pkg::result_t nr;
	logic              do_pop;

	assign beat_take = beat_valid && (rcnt_q != 2'd2);
	assign do_pop    = pop && !empty;
	assign empty     = rcnt_q == 2'd0;
	assign res       = rq_q[rrd_q];
	assign mul10     = {acc_q[6:0], 3'b000} + {acc_q[8:0], 1'b0};

	always_comb begin
		ph = beat.restart ? hhbp_pkg::PH_START : phase_q;
		vp = beat.restart ? 3'd0 : vpos_q;
		dc = beat.restart ? 2'd0 : dcnt_q;
		ac = beat.restart ? 10'd0 : acc_q;
		mi = beat.restart ? 1'b0 : minor_q;
		er = beat.restart ? hhbp_pkg::ERR_NONE : err_q;
		ph_n = ph; vp_n = vp; dc_n = dc; ac_n = ac; mi_n = mi; er_n = er;
		cls = hhbp_pkg::CLS_IDLE; first = 1'b0; fdone = 1'b0; hdone = 1'b0;
		e = hhbp_pkg::ERR_NONE;
		unique case (ph)
			hhbp_pkg::PH_START, hhbp_pkg::PH_QVERSION, hhbp_pkg::PH_RVERSION: begin
				if (ph == hhbp_pkg::PH_START && !message_kind) begin
					if (beat.is_tchar) begin
						cls = hhbp_pkg::CLS_METHOD; first = 1'b1;
						ph_n = hhbp_pkg::PH_METHOD;
					end else e = hhbp_pkg::ERR_METHOD_SEP;
				end else if (vp != 3'd7) begin
					if (beat.data != hhbp_pkg::ver_char(vp)) e = hhbp_pkg::ERR_VERSION;
					else begin
						cls = hhbp_pkg::CLS_VERSION; first = vp == 3'd0;
						vp_n = vp + 3'd1;
						if (ph == hhbp_pkg::PH_START) ph_n = hhbp_pkg::PH_RVERSION;
					end
				end else if (beat.data == hhbp_pkg::CH_ZERO || beat.data == hhbp_pkg::CH_ONE) begin
					mi_n = beat.data[0]; cls = hhbp_pkg::CLS_VERSION;
					ph_n = (ph == hhbp_pkg::PH_QVERSION) ? hhbp_pkg::PH_QEOL
						: hhbp_pkg::PH_RVER_SEP;
				end else e = hhbp_pkg::ERR_VERSION;
			end
			hhbp_pkg::PH_METHOD: begin
				if (beat.is_tchar) cls = hhbp_pkg::CLS_METHOD;
				else if (beat.is_sp) begin
					cls = hhbp_pkg::CLS_SEP; ph_n = hhbp_pkg::PH_TARGET_FIRST;
				end else e = hhbp_pkg::ERR_METHOD_SEP;
			end
			hhbp_pkg::PH_TARGET_FIRST, hhbp_pkg::PH_TARGET: begin
				if (beat.is_sp) begin
					cls = hhbp_pkg::CLS_SEP; ph_n = hhbp_pkg::PH_QVERSION;
				end else if (beat.is_vchar) begin
					cls = hhbp_pkg::CLS_TARGET; first = ph == hhbp_pkg::PH_TARGET_FIRST;
					ph_n = hhbp_pkg::PH_TARGET;
				end else e = hhbp_pkg::ERR_BAD_CHAR;
			end
			hhbp_pkg::PH_QEOL: begin
				if (beat.is_cr) begin
					cls = hhbp_pkg::CLS_EOL; ph_n = hhbp_pkg::PH_LINE_LF;
				end else if (beat.is_lf) begin
					cls = hhbp_pkg::CLS_EOL; ph_n = hhbp_pkg::PH_FIELD_START;
				end else e = hhbp_pkg::ERR_CRLF;
			end
			hhbp_pkg::PH_LINE_LF: begin
				if (beat.is_lf) begin
					cls = hhbp_pkg::CLS_EOL; ph_n = hhbp_pkg::PH_FIELD_START;
				end else e = hhbp_pkg::ERR_CRLF;
			end
			hhbp_pkg::PH_RVER_SEP: begin
				if (beat.is_sp) begin
					cls = hhbp_pkg::CLS_SEP; ph_n = hhbp_pkg::PH_CODE;
				end else e = hhbp_pkg::ERR_VER_SEP;
			end
			hhbp_pkg::PH_CODE: begin
				if (beat.is_digit) begin
					cls = hhbp_pkg::CLS_CODE; first = dc == 2'd0;
					ac_n = (beat.restart ? 10'd0 : mul10) + {6'd0, beat.data[3:0]};
					if (dc >= 2'd2) begin
						dc_n = 2'd0; ph_n = hhbp_pkg::PH_CODE_SEP;
					end else dc_n = dc + 2'd1;
				end else e = hhbp_pkg::ERR_CODE_DIGIT;
			end
			hhbp_pkg::PH_CODE_SEP: begin
				if (beat.is_sp) begin
					cls = hhbp_pkg::CLS_SEP; ph_n = hhbp_pkg::PH_REASON_FIRST;
				end else e = hhbp_pkg::ERR_CODE_SEP;
			end
			hhbp_pkg::PH_REASON_FIRST, hhbp_pkg::PH_REASON: begin
				if (beat.is_cr) begin
					cls = hhbp_pkg::CLS_EOL; ph_n = hhbp_pkg::PH_LINE_LF;
				end else if (beat.is_lf) begin
					cls = hhbp_pkg::CLS_EOL; ph_n = hhbp_pkg::PH_FIELD_START;
				end else if (beat.is_vchar) begin
					cls = hhbp_pkg::CLS_REASON; first = ph == hhbp_pkg::PH_REASON_FIRST;
					ph_n = hhbp_pkg::PH_REASON;
				end else e = hhbp_pkg::ERR_BAD_CHAR;
			end
			hhbp_pkg::PH_FIELD_START: begin
				if (beat.is_cr) begin
					cls = hhbp_pkg::CLS_EOL; ph_n = hhbp_pkg::PH_FINAL_LF;
				end else if (beat.is_lf) begin
					cls = hhbp_pkg::CLS_EOL; ph_n = hhbp_pkg::PH_DONE; hdone = 1'b1;
				end else if (beat.is_tchar) begin
					cls = hhbp_pkg::CLS_NAME; first = 1'b1; ph_n = hhbp_pkg::PH_NAME;
				end else e = hhbp_pkg::ERR_NAME_SEP;
			end
			hhbp_pkg::PH_NAME: begin
				if (beat.is_tchar) cls = hhbp_pkg::CLS_NAME;
				else if (beat.is_colon) begin
					cls = hhbp_pkg::CLS_SEP; ph_n = hhbp_pkg::PH_OWS;
				end else e = hhbp_pkg::ERR_NAME_SEP;
			end
			hhbp_pkg::PH_OWS, hhbp_pkg::PH_VALUE: begin
				if (ph == hhbp_pkg::PH_OWS && beat.is_sp) cls = hhbp_pkg::CLS_SEP;
				else if (beat.is_cr) begin
					cls = hhbp_pkg::CLS_EOL; ph_n = hhbp_pkg::PH_FIELD_LF;
				end else if (beat.is_lf) begin
					cls = hhbp_pkg::CLS_EOL; ph_n = hhbp_pkg::PH_FIELD_START;
					fdone = 1'b1;
				end else if (beat.is_vchar) begin
					cls = hhbp_pkg::CLS_VALUE; first = ph == hhbp_pkg::PH_OWS;
					ph_n = hhbp_pkg::PH_VALUE;
				end else e = hhbp_pkg::ERR_BAD_CHAR;
			end
			hhbp_pkg::PH_FIELD_LF: begin
				if (beat.is_lf) begin
					cls = hhbp_pkg::CLS_EOL; fdone = 1'b1; ph_n = hhbp_pkg::PH_FIELD_START;
				end else e = hhbp_pkg::ERR_CRLF;
			end
			hhbp_pkg::PH_FINAL_LF: begin
				if (beat.is_lf) begin
					cls = hhbp_pkg::CLS_EOL; hdone = 1'b1; ph_n = hhbp_pkg::PH_DONE;
				end else e = hhbp_pkg::ERR_CRLF;
			end
			default: ;
		endcase
		if (e != hhbp_pkg::ERR_NONE) begin
			er_n = e; ph_n = hhbp_pkg::PH_FAILED;
			cls = hhbp_pkg::CLS_IDLE; first = 1'b0; fdone = 1'b0; hdone = 1'b0;
		end
		nr.byte_class    = cls;
		nr.token_first   = first;
		nr.field_done    = fdone;
		nr.header_done   = hdone;
		nr.error_flag    = er_n != hhbp_pkg::ERR_NONE;
		nr.error_code    = er_n;
		nr.status_code   = ac_n;
		nr.version_minor = mi_n;
	end

	always_ff @(posedge clk) begin
		if (beat_take) begin
			rq_q[rwr_q] <= nr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hhbp_pkg::PH_START;
			vpos_q  <= 3'd0;
			dcnt_q  <= 2'd0;
			acc_q   <= 10'd0;
			minor_q <= 1'b0;
			err_q   <= hhbp_pkg::ERR_NONE;
			rrd_q   <= 1'b0;
			rwr_q   <= 1'b0;
			rcnt_q  <= 2'd0;
		end else begin
			if (beat_take) begin
				phase_q <= ph_n;
				vpos_q  <= vp_n;
				dcnt_q  <= dc_n;
				acc_q   <= ac_n;
				minor_q <= mi_n;
				err_q   <= er_n;
				rwr_q   <= ~rwr_q;
			end
			if (do_pop) begin
				rrd_q <= ~rrd_q;
			end
			rcnt_q <= rcnt_q + {1'b0, beat_take} - {1'b0, do_pop};
		end
	end

endmodule

>>> src/http1_header_byte_parser_top.sv
// top level of the http/1.x header byte parser: apb register, front and back parts
// depends on hhbp_pkg, hhbp_front, hhbp_back
//
// input channel: push a header byte with start_of_message set on the first
// byte of each header; an input beat is taken when push is high and full low.
// result channel: one result beat per input beat, in order, shown while empty
// is low and taken when pop is high.
// path: a pushed byte waits in the front queue and is parsed out of it into the
// result queue once that has room; it is then visible on the result ports.
// throughput: the parser takes one byte per cycle while the result queue has room.
// when pop is held low the result queue fills, the back part stops taking
// beats, the front queue fills and full rises; nothing is lost.
// register message_kind at byte address 0 (bit 0): 0 request, 1 response;
// write it only while idle. it is read when the first byte of a header is parsed.
// reset clears both queues, the parser state and message_kind.
module http1_header_byte_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic [7:0]  data_byte,
	input  logic        start_of_message,
	input  logic        push,
	output logic        full,
	output logic [3:0]  byte_class,
	output logic        token_first,
	output logic        field_done,
	output logic        header_done,
	output logic        error_flag,
	output logic [3:0]  error_code,
	output logic [9:0]  status_code,
	output logic        version_minor,
	output logic        empty,
	input  logic        pop
);

	logic                kind_q;
	hhbp_pkg::cls_beat_t beat;
	logic                beat_valid;
	logic                beat_take;
	hhbp_pkg::result_t   res;

	assign pready = 1'b1;
	assign prdata = (paddr == 1'b0) ? {31'd0, kind_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
			kind_q <= pwdata[0];
		end
	end

	hhbp_front u_front (
		.clk(clk), .arst_n(arst_n), .data_byte(data_byte),
		.start_of_message(start_of_message), .push(push), .full(full),
		.beat(beat), .beat_valid(beat_valid), .beat_take(beat_take)
	);

	hhbp_back u_back (
		.clk(clk), .arst_n(arst_n), .message_kind(kind_q), .beat(beat),
		.beat_valid(beat_valid), .beat_take(beat_take), .res(res),
		.empty(empty), .pop(pop)
	);

	assign byte_class    = res.byte_class;
	assign token_first   = res.token_first;
	assign field_done    = res.field_done;
	assign header_done   = res.header_done;
	assign error_flag    = res.error_flag;
	assign error_code    = res.error_code;
	assign status_code   = res.status_code;
	assign version_minor = res.version_minor;

endmodule

>>> src/hhbp_checker.sv
// port-level checks of the header byte parser
// depends on hhbp_pkg and http1_header_byte_parser_top ports; bound below
module hhbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [3:0] byte_class,
	input logic       field_done,
	input logic       header_done,
	input logic       error_flag,
	input logic [3:0] error_code
);

	a_flag_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (error_flag == (error_code != hhbp_pkg::ERR_NONE)))
		else $error("error flag and code disagree");

	a_done_eol: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (field_done || header_done)) |-> (byte_class == hhbp_pkg::CLS_EOL))
		else $error("done on a byte that is not a line end");

	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && error_flag) |-> (byte_class == hhbp_pkg::CLS_IDLE))
		else $error("class not idle while error latched");

	a_not_both: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(field_done && header_done))
		else $error("field and header done together");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(byte_class) && $stable(error_code)))
		else $error("waiting result beat changed");

endmodule

bind http1_header_byte_parser_top hhbp_checker u_hhbp_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.byte_class(byte_class), .field_done(field_done), .header_done(header_done),
	.error_flag(error_flag), .error_code(error_code)
);
